### sv/cdf_pkg.sv
package cdf_pkg;

   // field widths
   localparam int CHAN_W    = 16;
   localparam int WIDE_W    = 20;
   localparam int CODE_W    = 7;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 7;

   // code reduction and field masks
   localparam logic [CODE_W-1:0] CODE_COUNT = 7'd96;
   localparam logic [2:0]        ORDER_MASK = 3'h7;
   localparam logic [1:0]        PRED_MASK  = 2'h3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_XFORM_SEL    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INVERSE_MODE = 4'd1;

   // channel orders
   localparam logic [2:0] ORD_012 = 3'd0;
   localparam logic [2:0] ORD_021 = 3'd1;
   localparam logic [2:0] ORD_102 = 3'd2;
   localparam logic [2:0] ORD_120 = 3'd3;
   localparam logic [2:0] ORD_201 = 3'd4;
   localparam logic [2:0] ORD_210 = 3'd5;

   // primary predictor codes
   localparam logic [1:0] PP_ZERO  = 2'd0;
   localparam logic [1:0] PP_FULL  = 2'd1;
   localparam logic [1:0] PP_HALF  = 2'd2;
   localparam logic [1:0] PP_3HALF = 2'd3;

   // secondary predictor codes
   localparam logic [1:0] SP_ZERO  = 2'd0;
   localparam logic [1:0] SP_FIRST = 2'd1;
   localparam logic [1:0] SP_SECND = 2'd2;
   localparam logic [1:0] SP_MEAN  = 2'd3;

   typedef logic signed [CHAN_W-1:0] chan_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   // decoded configuration
   typedef struct packed {
      logic [2:0] order;
      logic [1:0] prim;
      logic [1:0] secnd;
      logic       inverse;
   } cfg_type;

   // source channel for slot k of an order
   function automatic logic [1:0] perm_sel(input logic [2:0] order, input logic [1:0] k);
      logic [5:0] row;
      begin
         unique case (order)
            ORD_012: row = {2'd0, 2'd1, 2'd2};
            ORD_021: row = {2'd0, 2'd2, 2'd1};
            ORD_102: row = {2'd1, 2'd0, 2'd2};
            ORD_120: row = {2'd1, 2'd2, 2'd0};
            ORD_201: row = {2'd2, 2'd0, 2'd1};
            ORD_210: row = {2'd2, 2'd1, 2'd0};
            default: row = {2'd0, 2'd1, 2'd2};
         endcase
         unique case (k)
            2'd0:    perm_sel = row[5:4];
            2'd1:    perm_sel = row[3:2];
            default: perm_sel = row[1:0];
         endcase
      end
   endfunction

   // slot that lands on channel j when the order is undone
   function automatic logic [1:0] inv_sel(input logic [2:0] order, input logic [1:0] j);
      logic [5:0] row;
      begin
         unique case (order)
            ORD_012: row = {2'd0, 2'd1, 2'd2};
            ORD_021: row = {2'd0, 2'd2, 2'd1};
            ORD_102: row = {2'd1, 2'd0, 2'd2};
            ORD_120: row = {2'd2, 2'd0, 2'd1};
            ORD_201: row = {2'd1, 2'd2, 2'd0};
            ORD_210: row = {2'd2, 2'd1, 2'd0};
            default: row = {2'd0, 2'd1, 2'd2};
         endcase
         unique case (j)
            2'd0:    inv_sel = row[5:4];
            2'd1:    inv_sel = row[3:2];
            default: inv_sel = row[1:0];
         endcase
      end
   endfunction

   // halve, rounding toward zero
   function automatic wide_type half_tz(input wide_type x);
      wide_type adj;
      begin
         adj     = x + (x[WIDE_W-1] ? wide_type'(1) : wide_type'(0));
         half_tz = adj >>> 1;
      end
   endfunction

endpackage

### sv/cdf_csr.sv
module cdf_csr import cdf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output cfg_type              cfg
);

   logic [CODE_W-1:0] xform_sel_ff, xform_sel_in;
   logic              inverse_ff, inverse_in;
   logic [CODE_W-1:0] code_red;

   assign csr_ready = 1'b1;

   // register writes, unknown indexes dropped
   always_comb begin
      xform_sel_in = xform_sel_ff;
      inverse_in   = inverse_ff;
      if (csr_valid) begin
         if (csr_index == REG_XFORM_SEL) begin
            xform_sel_in = csr_data[CODE_W-1:0];
         end else if (csr_index == REG_INVERSE_MODE) begin
            inverse_in = csr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xform_sel_ff <= '0;
         inverse_ff   <= 1'b0;
      end else begin
         xform_sel_ff <= xform_sel_in;
         inverse_ff   <= inverse_in;
      end
   end

   // fold codes past the last valid one back into range
   assign code_red = (xform_sel_ff >= CODE_COUNT) ? xform_sel_ff - CODE_COUNT
                                                  : xform_sel_ff;

   // reduced code keeps the order field at 0..5
   assign cfg.order   = code_red[6:4] & ORDER_MASK;
   assign cfg.prim    = code_red[3:2] & PRED_MASK;
   assign cfg.secnd   = code_red[1:0] & PRED_MASK;
   assign cfg.inverse = inverse_ff;

endmodule

### sv/cdf_core.sv
module cdf_core import cdf_pkg::*; (
   input  cfg_type  cfg,
   input  chan_type src0,
   input  chan_type src1,
   input  chan_type src2,
   output chan_type res0,
   output chan_type res1,
   output chan_type res2
);

   wide_type src_w [3];
   wide_type a, b, c;
   wide_type prim, secnd, mid, last;
   wide_type slot [3];

   assign src_w[0] = wide_type'(src0);
   assign src_w[1] = wide_type'(src1);
   assign src_w[2] = wide_type'(src2);

   // forward reorders on the way in, inverse on the way out
   always_comb begin
      if (cfg.inverse) begin
         a = src_w[0];
         b = src_w[1];
         c = src_w[2];
      end else begin
         a = src_w[perm_sel(cfg.order, 2'd0)];
         b = src_w[perm_sel(cfg.order, 2'd1)];
         c = src_w[perm_sel(cfg.order, 2'd2)];
      end
   end

   // primary prediction from the first channel
   always_comb begin
      unique case (cfg.prim)
         PP_ZERO:  prim = '0;
         PP_FULL:  prim = a;
         PP_HALF:  prim = half_tz(a);
         PP_3HALF: prim = half_tz(a + (a <<< 1));
         default:  prim = '0;
      endcase
   end

   assign mid = cfg.inverse ? b + prim : b - prim;

   // secondary prediction uses the plain second channel, restored when inverse
   always_comb begin
      wide_type sec_in;
      sec_in = cfg.inverse ? mid : b;
      unique case (cfg.secnd)
         SP_ZERO:  secnd = '0;
         SP_FIRST: secnd = a;
         SP_SECND: secnd = sec_in;
         SP_MEAN:  secnd = half_tz(a + sec_in);
         default:  secnd = '0;
      endcase
   end

   assign last = cfg.inverse ? c + secnd : c - secnd;

   assign slot[0] = a;
   assign slot[1] = mid;
   assign slot[2] = last;

   // wrap to channel width, undo the order in inverse mode
   always_comb begin
      wide_type o0, o1, o2;
      if (cfg.inverse) begin
         o0 = slot[inv_sel(cfg.order, 2'd0)];
         o1 = slot[inv_sel(cfg.order, 2'd1)];
         o2 = slot[inv_sel(cfg.order, 2'd2)];
      end else begin
         o0 = slot[0];
         o1 = slot[1];
         o2 = slot[2];
      end
      res0 = o0[CHAN_W-1:0];
      res1 = o1[CHAN_W-1:0];
      res2 = o2[CHAN_W-1:0];
   end

endmodule

### sv/color_decorrelation_filter_unit.sv
// path: request beat -> input register -> result register -> response beat
// throughput: one pixel per cycle while rsp_stall is low; two-stage pipeline
//   (input register, transform logic, result register)
// reset: synchronous, active high; clears both pipeline valids,
//   the transform code and the inverse mode to zero
module color_decorrelation_filter_unit import cdf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [15:0]   req_chan_b,
   input  logic signed [15:0]   req_chan_g,
   input  logic signed [15:0]   req_chan_r,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [15:0]   rsp_res_first,
   output logic signed [15:0]   rsp_res_second,
   output logic signed [15:0]   rsp_res_third,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cfg_type  cfg;
   logic     in_vld_ff, in_vld_in;
   logic     out_vld_ff, out_vld_in;
   chan_type in_b_ff, in_g_ff, in_r_ff;
   chan_type out0_ff, out1_ff, out2_ff;
   chan_type res0, res1, res2;
   logic     out_move, in_move;

   cdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cdf_core u_core (
      .cfg  (cfg),
      .src0 (in_b_ff),
      .src1 (in_g_ff),
      .src2 (in_r_ff),
      .res0 (res0),
      .res1 (res1),
      .res2 (res2)
   );

   // pipeline advance
   assign out_move  = !out_vld_ff || !rsp_stall;
   assign in_move   = !in_vld_ff || out_move;
   assign req_stall = !in_move;

   always_comb begin
      in_vld_in  = in_move ? req_valid : in_vld_ff;
      out_vld_in = out_move ? in_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // input beat register
   always_ff @(posedge clock) begin
      if (in_move && req_valid) begin
         in_b_ff <= req_chan_b;
         in_g_ff <= req_chan_g;
         in_r_ff <= req_chan_r;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_move && in_vld_ff) begin
         out0_ff <= res0;
         out1_ff <= res1;
         out2_ff <= res2;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_res_first  = out0_ff;
   assign rsp_res_second = out1_ff;
   assign rsp_res_third  = out2_ff;

endmodule
